// ----- design/assert_macros.svh -----
// Shared assertion macros for the frame slowdown monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside of reset.
`define FSMON_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("fsmon assertion failed");

// Check that cond never holds outside of reset.
`define FSMON_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("fsmon forbidden condition seen");

`endif

// ----- design/fsmon_pkg.sv -----
package fsmon_pkg;

	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned RATE_W    = 10;
	localparam int unsigned PCT_W     = 16;
	localparam int unsigned SUM_W     = 24;
	localparam int unsigned PROD_W    = 39;
	localparam int unsigned DIV_REM_W = 10;
	localparam int unsigned DIV_DVD_W = 16;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [RATE_W-1:0]    RATE_RESET    = 10'd20;
	localparam logic [RATE_W-1:0]    RATE_MIN      = 10'd1;
	localparam logic [RATE_W-1:0]    RATE_MAX      = 10'd1000;
	localparam logic [6:0]           PCT_SCALE     = 7'd100;
	localparam logic [PCT_W-1:0]     PCT_MAX       = 16'hFFFF;
	// 1000 left-aligned in the dividend shift register
	localparam logic [DIV_DVD_W-1:0] EXP_DIVIDEND  = 16'd64000;
	localparam logic [DIV_CNT_W-1:0] STEPS_EXPECT  = 5'd10;
	localparam logic [DIV_CNT_W-1:0] STEPS_QUOT16  = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP,
		ST_CHECK,
		ST_MUL,
		ST_SAT,
		ST_PCT,
		ST_SCAN_WAIT,
		ST_MEAN,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_REM_W-1:0] divisor;
		logic [DIV_REM_W-1:0] rem_init;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] sum;
		logic [PCT_W-1:0] peak;
	} scan_stat_t;

endpackage

// ----- design/fsmon_ram.sv -----
module fsmon_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 50,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/fsmon_div.sv -----
`include "assert_macros.svh"

module fsmon_div import fsmon_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_REM_W-1:0] divisor_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [PCT_W-1:0]     quo_q;

	logic [DIV_REM_W:0] trial;
	logic [DIV_REM_W:0] diff;
	logic               ge;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		trial = {rem_q, dvd_q[DIV_DVD_W-1]};
		diff  = trial - {1'b0, divisor_q};
		ge    = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= req.rem_init;
			dvd_q     <= req.dividend;
			quo_q     <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[PCT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	`FSMON_NEVER(a_div_start_busy, clk, arst_n, req.start && (cnt_q != '0))

endmodule

// ----- design/fsmon_scan.sv -----
`include "assert_macros.svh"

module fsmon_scan import fsmon_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 50,
	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
	localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW-1:0]    fill,
	input  logic [AW-1:0]    skip,
	input  logic [PCT_W-1:0] rdata,
	output logic [AW-1:0]    raddr,
	output scan_stat_t       stat
);

	localparam logic [CW-1:0] LAST = CW'(WINDOW_DEPTH - 1);

	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             rd_s1;
	logic             take_s1;
	logic             last_s1;
	logic             done_q;
	logic [SUM_W-1:0] sum_q;
	logic [PCT_W-1:0] peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			run_q   <= 1'b0;
			rd_s1   <= 1'b0;
			take_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			rd_s1   <= run_q;
			// unwritten entries read as zero; the slot about to be overwritten is left out
			take_s1 <= run_q && (cnt_q < fill) && (cnt_q[AW-1:0] != skip);
			last_s1 <= run_q && (cnt_q == LAST);
			if (start) begin
				cnt_q  <= '0;
				run_q  <= 1'b1;
				done_q <= 1'b0;
			end else if (run_q) begin
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (rd_s1 && last_s1) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q  <= '0;
			peak_q <= '0;
		end else if (rd_s1 && take_s1) begin
			sum_q <= sum_q + SUM_W'(rdata);
			if (rdata > peak_q) begin
				peak_q <= rdata;
			end
		end
	end

	assign raddr     = cnt_q[AW-1:0];
	assign stat.done = done_q;
	assign stat.sum  = sum_q;
	assign stat.peak = peak_q;

	`FSMON_NEVER(a_scan_done_idle, clk, arst_n, done_q && (run_q || rd_s1))

endmodule

// ----- design/frame_slowdown_monitor.sv -----
// Channel     Direction  Handshake          Payload
// cfg         in         cfg_wen            cfg_wdata (frames_per_second)
// in          in         in_valid/in_stall  timestamp_ms
// out         out        out_valid/out_stall slowdown_now, slowdown_mean, slowdown_peak
//
// The result is set by the history scan, one RAM read per entry, then the sum is latched
// and the mean is formed by reciprocal multiply; the serial divides run alongside the scan.
// Reset clears previous stamp, write slot and fill count; entries at or above the fill
// count read as zero. A stalled result holds in the output register while the next input
// is taken; only the final history write waits for the output to drain.
`include "assert_macros.svh"

module frame_slowdown_monitor import fsmon_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [RATE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [STAMP_W-1:0] timestamp_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PCT_W-1:0]   slowdown_now,
	output logic [PCT_W-1:0]   slowdown_mean,
	output logic [PCT_W-1:0]   slowdown_peak
);

	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

	// mean = (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for any sum below 2^SUM_W
	localparam int unsigned MEAN_SHIFT =
		SUM_W + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0);
	localparam int unsigned RECIP_W    = SUM_W + 1;
	localparam int unsigned MPROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MEAN_RECIP =
		RECIP_W'(((64'd1 << MEAN_SHIFT) / 64'(WINDOW_DEPTH)) + 64'd1);

	ctl_state_t state_q, state_nxt;

	// configuration and history bookkeeping
	logic [RATE_W-1:0]  rate_q;
	logic [STAMP_W-1:0] prev_q;
	logic [AW-1:0]      slot_q;
	logic [CW-1:0]      fill_q;

	// per-transaction working registers
	logic [STAMP_W-1:0]   elapsed_q;
	logic                 first_q;
	logic [RATE_W-1:0]    exp_q;
	logic [STAMP_W-1:0]   excess_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PCT_W-1:0]     now_q;
	logic [PCT_W-1:0]     peak_q;
	logic [SUM_W-1:0]     sum_q;
	logic [PCT_W-1:0]     mean_q;

	// output register
	logic               out_valid_q;
	logic [PCT_W-1:0]   now_out_q;
	logic [PCT_W-1:0]   mean_out_q;
	logic [PCT_W-1:0]   peak_out_q;

	div_req_t   div_req;
	div_rsp_t   div_rsp;
	scan_stat_t scan_stat;
	logic       scan_start;
	logic [AW-1:0]    mem_raddr;
	logic [PCT_W-1:0] mem_rdata;
	logic             mem_we;
	logic             out_load;
	logic             out_free;
	logic             not_late;
	logic             sat_hit;
	logic [RATE_W-1:0] rate_eff;
	logic [SUM_W-1:0]  sum_total;
	logic [MPROD_W-1:0] mean_prod;

	fsmon_ram #(
		.WIDTH (PCT_W),
		.DEPTH (WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (now_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fsmon_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fsmon_scan #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.fill   (fill_q),
		.skip   (slot_q),
		.rdata  (mem_rdata),
		.raddr  (mem_raddr),
		.stat   (scan_stat)
	);

	always_comb begin
		// clamp the rate so the divisor is never zero
		if (rate_q < RATE_MIN) begin
			rate_eff = RATE_MIN;
		end else if (rate_q > RATE_MAX) begin
			rate_eff = RATE_MAX;
		end else begin
			rate_eff = rate_q;
		end
		out_free  = !out_valid_q || !out_stall;
		not_late  = first_q || (elapsed_q <= STAMP_W'(exp_q));
		// a quotient of 2^16 or more saturates; below that the high part fits the remainder
		sat_hit   = (prod_q >= PROD_W'({exp_q, {PCT_W{1'b0}}}));
		sum_total = scan_stat.sum + SUM_W'(now_q);
		mean_prod = MPROD_W'(sum_q) * MPROD_W'(MEAN_RECIP);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_nxt = ST_EXP;
			ST_EXP:       if (div_rsp.done) state_nxt = ST_CHECK;
			ST_CHECK:     state_nxt = not_late ? ST_SCAN_WAIT : ST_MUL;
			ST_MUL:       state_nxt = ST_SAT;
			ST_SAT:       state_nxt = sat_hit ? ST_SCAN_WAIT : ST_PCT;
			ST_PCT:       if (div_rsp.done) state_nxt = ST_SCAN_WAIT;
			ST_SCAN_WAIT: if (scan_stat.done) state_nxt = ST_MEAN;
			ST_MEAN:      state_nxt = ST_FINISH;
			ST_FINISH:    if (out_free) state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		div_req    = '0;
		scan_start = 1'b0;
		out_load   = 1'b0;
		mem_we     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					// expected frame time = 1000 / rate
					div_req.start    = 1'b1;
					div_req.divisor  = rate_eff;
					div_req.rem_init = '0;
					div_req.dividend = EXP_DIVIDEND;
					div_req.steps    = STEPS_EXPECT;
					scan_start       = 1'b1;
				end
			end
			ST_SAT: begin
				if (!sat_hit) begin
					div_req.start    = 1'b1;
					div_req.divisor  = exp_q;
					div_req.rem_init = prod_q[PCT_W+DIV_REM_W-1:PCT_W];
					div_req.dividend = prod_q[PCT_W-1:0];
					div_req.steps    = STEPS_QUOT16;
				end
			end
			ST_FINISH: begin
				out_load = out_free;
				mem_we   = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_RESET;
			prev_q      <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				rate_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE && in_valid) begin
				prev_q <= timestamp_ms;
			end
			if (mem_we) begin
				// advance the circular write slot; count entries until the window is full
				slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != CW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					elapsed_q <= timestamp_ms - prev_q;
					first_q   <= (prev_q == '0);
				end
			end
			ST_EXP: begin
				if (div_rsp.done) begin
					exp_q <= div_rsp.quot[RATE_W-1:0];
				end
			end
			ST_CHECK: begin
				excess_q <= elapsed_q - STAMP_W'(exp_q);
				if (not_late) begin
					now_q <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(excess_q) * PROD_W'(PCT_SCALE);
			end
			ST_SAT: begin
				if (sat_hit) begin
					now_q <= PCT_MAX;
				end
			end
			ST_PCT: begin
				if (div_rsp.done) begin
					now_q <= div_rsp.quot;
				end
			end
			ST_SCAN_WAIT: begin
				if (scan_stat.done) begin
					peak_q <= (now_q > scan_stat.peak) ? now_q : scan_stat.peak;
					sum_q  <= sum_total;
				end
			end
			ST_MEAN: begin
				mean_q <= mean_prod[MEAN_SHIFT +: PCT_W];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			now_out_q  <= now_q;
			mean_out_q <= mean_q;
			peak_out_q <= peak_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign slowdown_now  = now_out_q;
	assign slowdown_mean = mean_out_q;
	assign slowdown_peak = peak_out_q;

	`FSMON_NEVER(a_no_overwrite, clk, arst_n, out_load && out_valid_q && out_stall)
	`FSMON_ASSERT(a_mean_after_scan, clk, arst_n, (state_q == ST_MEAN) |-> scan_stat.done)
	`FSMON_ASSERT(a_slot_tracks_fill, clk, arst_n,
		(fill_q != CW'(WINDOW_DEPTH)) |-> (slot_q == fill_q[AW-1:0]))

endmodule

// ----- dv/tb_frame_slowdown_monitor.sv -----
`timescale 1ns / 100ps

module tb_frame_slowdown_monitor;
	import fsmon_pkg::*;

	localparam int unsigned WINDOW       = 50;
	localparam int unsigned MS_PER_SEC   = 1000;
	localparam int unsigned MAX_WAIT     = 18;
	// Leave margin on top of the block latency.
	localparam int unsigned SETTLE       = 2 * WINDOW + 20;
	localparam int unsigned SQUEEZE_LEN  = 400;
	localparam int unsigned PHASE_ITEMS  = 128;
	localparam int unsigned PHASE_COUNT  = 11;
	// Cycles without any accepted transaction before the run is declared hung.
	localparam int unsigned HANG_LIMIT   = 4000;

	typedef struct packed {
		logic [PCT_W-1:0] now;
		logic [PCT_W-1:0] mean;
		logic [PCT_W-1:0] peak;
	} report_t;

	// One row of the directed sequence. When known is set, the report is typed in
	// by hand; otherwise the frame model supplies it.
	typedef struct packed {
		bit                 set_rate;
		logic [RATE_W-1:0]  rate;
		logic [STAMP_W-1:0] stamp;
		bit                 known;
		logic [PCT_W-1:0]   now;
		logic [PCT_W-1:0]   mean;
		logic [PCT_W-1:0]   peak;
	} frame_row_t;

	localparam int unsigned DIR_ROWS = 19;
	localparam frame_row_t DIRECTED [DIR_ROWS] = '{
		// first frame after reset has no predecessor
		'{1'b0, 10'd0,    32'd1000,        1'b1, 16'd0,     16'd0,    16'd0},
		// exactly on time at the reset rate of 20 fps (50 ms budget)
		'{1'b0, 10'd0,    32'd1050,        1'b1, 16'd0,     16'd0,    16'd0},
		// 100 ms frame: 50 ms over a 50 ms budget
		'{1'b0, 10'd0,    32'd1150,        1'b1, 16'd100,   16'd2,    16'd100},
		// clock steps back by one: wraps to a huge frame time, saturates
		'{1'b0, 10'd0,    32'd1149,        1'b1, 16'd65535, 16'd1312, 16'd65535},
		// zero stamp still measures against the previous frame
		'{1'b0, 10'd0,    32'd0,           1'b1, 16'd65535, 16'd2623, 16'd65535},
		// previous stamp was zero, so this frame counts as the first one
		'{1'b0, 10'd0,    32'hFFFF_FFFF,   1'b1, 16'd0,     16'd2623, 16'd65535},
		// difference wraps through the top of the counter
		'{1'b0, 10'd0,    32'd99,          1'b1, 16'd100,   16'd2625, 16'd65535},
		// rate zero behaves as 1 fps
		'{1'b1, 10'd0,    32'd2099,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b0, 10'd0,    32'd3099,        1'b0, 16'd0,     16'd0,    16'd0},
		// top of the legal range: 1 ms budget
		'{1'b1, 10'd1000, 32'd3100,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b0, 10'd0,    32'd3102,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b0, 10'd0,    32'd3758,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b0, 10'd0,    32'd4415,        1'b0, 16'd0,     16'd0,    16'd0},
		// rate above range clamps to 1000
		'{1'b1, 10'd1023, 32'd4418,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b1, 10'd1,    32'd6417,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b1, 10'd7,    32'd6560,        1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b0, 10'd0,    32'h8000_199F,   1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b1, 10'd999,  32'h8000_19A0,   1'b0, 16'd0,     16'd0,    16'd0},
		'{1'b1, 10'd20,   32'h8000_1A00,   1'b0, 16'd0,     16'd0,    16'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [RATE_W-1:0]  cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [STAMP_W-1:0] timestamp_ms;
	logic               out_valid;
	logic               out_stall;
	logic [PCT_W-1:0]   slowdown_now;
	logic [PCT_W-1:0]   slowdown_mean;
	logic [PCT_W-1:0]   slowdown_peak;

	// Frame model state: a private copy of what the block keeps.
	logic [RATE_W-1:0]  rate_cfg;
	logic [STAMP_W-1:0] last_stamp;
	logic [PCT_W-1:0]   history_q [WINDOW];
	int unsigned        slot_q;

	report_t            pending_reports [$];

	// Hand-typed report riding along with the frame currently offered.
	bit                 offer_known;
	report_t            offer_report;

	bit                 busy_mode;
	bit                 squeeze_req;
	bit                 failed;
	int unsigned        frames_in;
	int unsigned        reports_out;
	int unsigned        rates_set;
	int unsigned        mismatches;
	int unsigned        idle_cycles;

	frame_slowdown_monitor #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.timestamp_ms (timestamp_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slowdown_now (slowdown_now),
		.slowdown_mean(slowdown_mean),
		.slowdown_peak(slowdown_peak)
	);

	// Clock, reset and known values on every input from time zero.
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		timestamp_ms = '0;
		out_stall    = 1'b0;
		offer_known  = 1'b0;
		offer_report = '0;
		busy_mode    = 1'b0;
		squeeze_req  = 1'b0;
		fork
			forever #1 clk = ~clk;
			begin
				repeat (5) @(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// Advance the frame model by one frame and return the report it gives.
	function automatic report_t slowdown_forecast(input logic [STAMP_W-1:0] stamp);
		logic [RATE_W-1:0]  eff_rate;
		logic [STAMP_W-1:0] span;
		logic [STAMP_W-1:0] budget;
		longint unsigned    pct;
		int unsigned        total;
		report_t            rep;
		eff_rate = rate_cfg;
		if (eff_rate < RATE_MIN) begin
			eff_rate = RATE_MIN;
		end
		if (eff_rate > RATE_MAX) begin
			eff_rate = RATE_MAX;
		end
		budget = MS_PER_SEC / eff_rate;
		pct = 0;
		// A zero previous stamp means there is no previous frame to measure against.
		if (last_stamp != '0) begin
			span = stamp - last_stamp;
			if (span > budget) begin
				pct = longint'(span - budget) * PCT_SCALE / budget;
				if (pct > PCT_MAX) begin
					pct = PCT_MAX;
				end
			end
		end
		last_stamp = stamp;
		history_q[slot_q] = pct[PCT_W-1:0];
		slot_q = (slot_q + 1 == WINDOW) ? 0 : slot_q + 1;
		total = 0;
		rep.peak = '0;
		for (int i = 0; i < WINDOW; i++) begin
			total += history_q[i];
			if (history_q[i] > rep.peak) begin
				rep.peak = history_q[i];
			end
		end
		rep.now = pct[PCT_W-1:0];
		rep.mean = total / WINDOW;
		return rep;
	endfunction

	// Sample both channels at the rising edge: feed accepted frames to the model,
	// compare accepted reports against the oldest pending one, and watch for a hang.
	always @(posedge clk or negedge arst_n) begin
		report_t model_rep;
		report_t want;
		bit      moved;
		if (!arst_n) begin
			rate_cfg    = RATE_RESET;
			last_stamp  = '0;
			slot_q      = 0;
			idle_cycles = 0;
			for (int i = 0; i < WINDOW; i++) begin
				history_q[i] = '0;
			end
		end else begin
			moved = 1'b0;
			if (cfg_wen) begin
				rate_cfg = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				frames_in++;
				model_rep = slowdown_forecast(timestamp_ms);
				pending_reports.push_back(offer_known ? offer_report : model_rep);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				reports_out++;
				if (pending_reports.size() == 0) begin
					$error("report arrived with no frame pending: now %0d mean %0d peak %0d",
						slowdown_now, slowdown_mean, slowdown_peak);
					failed = 1'b1;
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (slowdown_now !== want.now) begin
						$error("slowdown_now: expected %0d, got %0d", want.now, slowdown_now);
						failed = 1'b1;
						mismatches++;
					end
					if (slowdown_mean !== want.mean) begin
						$error("slowdown_mean: expected %0d, got %0d", want.mean, slowdown_mean);
						failed = 1'b1;
						mismatches++;
					end
					if (slowdown_peak !== want.peak) begin
						$error("slowdown_peak: expected %0d, got %0d", want.peak, slowdown_peak);
						failed = 1'b1;
						mismatches++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("No transaction for %0d cycles, %0d reports still pending",
					HANG_LIMIT, pending_reports.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Report side: stall for a random number of cycles before each report, and hold
	// off for a long stretch when asked so that the block backs up into its input.
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_stall <= 1'b1;
				repeat (SQUEEZE_LEN) @(negedge clk);
			end
			hold = busy_mode ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Offer one frame after a random gap and hold it until the block takes it.
	// Valid stays high across back-to-back frames.
	task automatic offer_stamp(input logic [STAMP_W-1:0] stamp, input bit known,
			input report_t rep);
		int unsigned gap;
		gap = busy_mode ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		timestamp_ms <= stamp;
		offer_known  <= known;
		offer_report <= rep;
		do @(posedge clk); while (in_stall);
	endtask

	// Change the frame rate only once every report is back and the block has
	// had time to finish its last history write.
	task automatic write_rate(input logic [RATE_W-1:0] rate);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= rate;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		rates_set++;
	endtask

	initial begin
		logic [RATE_W-1:0]  plan [PHASE_COUNT];
		logic [RATE_W-1:0]  rate;
		logic [STAMP_W-1:0] stamp;
		int unsigned        budget;
		int unsigned        pick;
		frame_row_t         row;
		report_t            hand_rep;
		failed      = 1'b0;
		frames_in   = 0;
		reports_out = 0;
		rates_set   = 0;
		mismatches  = 0;
		@(posedge arst_n);

		// Directed frames: first frame, on-time edge, wrap, saturation and rate clamps.
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.set_rate) begin
				write_rate(row.rate);
			end
			hand_rep = '{now: row.now, mean: row.mean, peak: row.peak};
			offer_stamp(row.stamp, row.known, hand_rep);
		end

		// Random phases: extremes of the rate first, then arbitrary settings.
		plan = '{10'd20, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd7, 10'd333, 10'd999,
			10'd0, 10'd0, 10'd0};
		for (int p = 8; p < PHASE_COUNT; p++) begin
			plan[p] = $urandom_range(0, 1023);
		end
		stamp = DIRECTED[DIR_ROWS-1].stamp;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			rate = plan[p];
			write_rate(rate);
			// Run a couple of phases flat out; one of them also holds the report side off.
			busy_mode = (p == 1 || p == 4);
			if (p == 4) begin
				squeeze_req = 1'b1;
			end
			budget = MS_PER_SEC / ((rate == 0) ? 1 : (rate > RATE_MAX) ? RATE_MAX : rate);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				// Mostly a steady frame clock with jitter around the budget; the rest
				// are long stalls, wraps, restarts from zero, stray stamps and small steps back.
				if (pick < 65) begin
					stamp = stamp + $urandom_range(0, 3 * budget);
				end else if (pick < 82) begin
					stamp = stamp + $urandom_range(0, 700 * budget + 10);
				end else if (pick < 87) begin
					stamp = stamp + $urandom();
				end else if (pick < 91) begin
					stamp = '0;
				end else if (pick < 96) begin
					stamp = $urandom();
				end else begin
					stamp = stamp - $urandom_range(1, 50);
				end
				offer_stamp(stamp, 1'b0, '0);
			end
		end
		busy_mode = 1'b0;

		// Drain: wait for every report, then give the block time to show strays.
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d frames over %0d rate settings, including wraps, zero stamps,",
			frames_in, rates_set);
		$display("saturation and a long report hold-off; %0d reports, %0d field mismatches",
			reports_out, mismatches);
		if (!failed) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/fsmon_pkg.sv
design/fsmon_ram.sv
design/fsmon_div.sv
design/fsmon_scan.sv
design/frame_slowdown_monitor.sv
dv/tb_frame_slowdown_monitor.sv
